### hw/rtl/line_feature_displacement_tracker_assert.svh
// Assertion macros shared by the tracker RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef LINE_FEATURE_DISPLACEMENT_TRACKER_ASSERT_SVH
`define LINE_FEATURE_DISPLACEMENT_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LFDT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LFDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lfdt_pkg.sv
// Shared types and constants of the line feature displacement tracker.
// No dependencies; imported by every tracker module except lfdt_ram.
`timescale 1ns / 1ps

package lfdt_pkg;

	// Feature table entries per bank, and the job queue between front and back
	localparam int TABLE_DEPTH = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = $clog2(2 * TABLE_DEPTH);

	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 9;
	localparam int POS_W    = 13;
	localparam int LINE_W   = 12;
	localparam int BRIGHT_W = 6;
	localparam int GAP_W    = 8;
	localparam int LEVEL_W  = 3;

	localparam logic [SUM_W-1:0] SUM_MAX = 9'd511;

	// Quantized levels
	localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_5 = 3'd5;

	// Register reset values
	localparam logic [11:0] RST_LINE_LENGTH   = 12'd768;
	localparam logic [23:0] RST_LEVEL1        = 24'd10000000;
	localparam logic [23:0] RST_LEVEL3        = 24'd12000000;
	localparam logic [23:0] RST_LEVEL4        = 24'd13000000;
	localparam logic [23:0] RST_LEVEL5        = 24'd14000000;
	localparam logic [7:0]  RST_GAP_LIMIT     = 8'd8;
	localparam logic [7:0]  RST_MATCH_WINDOW  = 8'd10;
	localparam logic [5:0]  RST_FEATURE_LIMIT = 6'd47;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_LINE_LENGTH   = 3'd0,
		REG_LEVEL1        = 3'd1,
		REG_LEVEL3        = 3'd2,
		REG_LEVEL4        = 3'd3,
		REG_LEVEL5        = 3'd4,
		REG_GAP_LIMIT     = 3'd5,
		REG_MATCH_WINDOW  = 3'd6,
		REG_FEATURE_LIMIT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] line_length;
		logic [23:0] level1_threshold;
		logic [23:0] level3_threshold;
		logic [23:0] level4_threshold;
		logic [23:0] level5_threshold;
		logic [7:0]  gap_limit;
		logic [7:0]  match_window;
		logic [5:0]  feature_limit;
	} cfg_t;

	// One ended feature handed from the front to the back
	typedef struct packed {
		logic             bank;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] prev_cnt;
		logic [SUM_W-1:0] sum;
		logic [POS_W-1:0] pos;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WRITE,
		BK_SEARCH
	} back_state_t;

	// Table address of entry idx of a bank
	function automatic logic [ADDR_W-1:0] tbl_addr(input logic bank, input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] base;
		base = bank ? ADDR_W'(TABLE_DEPTH) : '0;
		return base + ADDR_W'(idx);
	endfunction

endpackage

### hw/rtl/line_feature_displacement_tracker.sv
// With the matcher idle, a closing sample's transfer queues a job; the matcher pops it, writes
// the entry, then reads the previous line's table in order and registers the first match on m_tdata.
// Throughput: one sample per cycle while the 4-deep job queue has room; each stored feature
// holds the matcher for a table write and a search of the previous line's table, one read per cycle.
// Reset: arst_n asynchronous, active low; clears all control state and loads register
// defaults. The feature table is not cleared; only written entries are ever read.
`timescale 1ns / 1ps

module line_feature_displacement_tracker (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample
	// Displacement stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [12:0] displacement, [15:13] zero
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lfdt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     reg_wr;
	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_vld;
	job_t     push_job;
	job_t     pop_job;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length      <= RST_LINE_LENGTH;
			cfg_q.level1_threshold <= RST_LEVEL1;
			cfg_q.level3_threshold <= RST_LEVEL3;
			cfg_q.level4_threshold <= RST_LEVEL4;
			cfg_q.level5_threshold <= RST_LEVEL5;
			cfg_q.gap_limit        <= RST_GAP_LIMIT;
			cfg_q.match_window     <= RST_MATCH_WINDOW;
			cfg_q.feature_limit    <= RST_FEATURE_LIMIT;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_LINE_LENGTH:   cfg_q.line_length      <= pwdata[11:0];
				REG_LEVEL1:        cfg_q.level1_threshold <= pwdata[23:0];
				REG_LEVEL3:        cfg_q.level3_threshold <= pwdata[23:0];
				REG_LEVEL4:        cfg_q.level4_threshold <= pwdata[23:0];
				REG_LEVEL5:        cfg_q.level5_threshold <= pwdata[23:0];
				REG_GAP_LIMIT:     cfg_q.gap_limit        <= pwdata[7:0];
				REG_MATCH_WINDOW:  cfg_q.match_window     <= pwdata[7:0];
				REG_FEATURE_LIMIT: cfg_q.feature_limit    <= pwdata[5:0];
				default:           cfg_q.line_length      <= cfg_q.line_length;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			REG_LINE_LENGTH:   prdata = {20'd0, cfg_q.line_length};
			REG_LEVEL1:        prdata = {8'd0, cfg_q.level1_threshold};
			REG_LEVEL3:        prdata = {8'd0, cfg_q.level3_threshold};
			REG_LEVEL4:        prdata = {8'd0, cfg_q.level4_threshold};
			REG_LEVEL5:        prdata = {8'd0, cfg_q.level5_threshold};
			REG_GAP_LIMIT:     prdata = {24'd0, cfg_q.gap_limit};
			REG_MATCH_WINDOW:  prdata = {24'd0, cfg_q.match_window};
			REG_FEATURE_LIMIT: prdata = {26'd0, cfg_q.feature_limit};
			default:           prdata = '0;
		endcase
	end

	lfdt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_job   (push_job)
	);

	lfdt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.vld     (q_vld),
		.pop_job (pop_job)
	);

	lfdt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.match_window(cfg_q.match_window),
		.q_vld       (q_vld),
		.q_job       (pop_job),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

### hw/rtl/lfdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/lfdt_fifo.sv
// Short job queue between the classifying front and the matching back.
// Depends on lfdt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "line_feature_displacement_tracker_assert.svh"

module lfdt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lfdt_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          vld,
	output lfdt_pkg::job_t pop_job
);
	import lfdt_pkg::*;

	localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	job_t            slot_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;

	assign full    = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign vld     = (cnt_q != '0);
	assign pop_job = slot_q[rd_ptr_q];

	// Payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`LFDT_ASSERT_SAME(a_no_overflow, push, !full || pop, "job queue overflow")
	`LFDT_ASSERT_SAME(a_no_underflow, pop, vld, "job queue underflow")
	`LFDT_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= QC_W'(QUEUE_DEPTH), "job queue count out of range")

endmodule

### hw/rtl/lfdt_front.sv
// Front part: quantizes samples, tracks the open feature and line position,
// and queues ended features for storing and matching. Depends on lfdt_pkg.
`timescale 1ns / 1ps

module lfdt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfdt_pkg::cfg_t          cfg,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [23:0]             s_tdata,  // [23:0] sample
	input  logic                    q_full,
	output logic                    q_push,
	output lfdt_pkg::job_t          q_job
);
	import lfdt_pkg::*;

	logic [SUM_W-1:0]    rsum_q;
	logic [BRIGHT_W-1:0] bc_q;
	logic [GAP_W-1:0]    gap_q;
	logic [LINE_W-1:0]   si_q;
	logic                bank_q;
	logic [CNT_W-1:0]    cnt_q [2];

	logic [LEVEL_W-1:0]  level;
	logic                accept;
	logic                swap;
	logic                bank_n;
	logic [CNT_W-1:0]    cnt_cur;
	logic [CNT_W-1:0]    cnt_cur_n;
	logic [BRIGHT_W-1:0] bc_eff;
	logic [LINE_W-1:0]   si_n;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    rsum_n;
	logic [BRIGHT_W-1:0] bc_n;
	logic [GAP_W-1:0]    gap_n;
	logic                close;
	logic                store;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Quantizer: highest exceeded threshold wins
	always_comb begin
		if (s_tdata > cfg.level5_threshold) begin
			level = LEVEL_5;
		end else if (s_tdata > cfg.level4_threshold) begin
			level = LEVEL_4;
		end else if (s_tdata > cfg.level3_threshold) begin
			level = LEVEL_3;
		end else if (s_tdata > cfg.level1_threshold) begin
			level = LEVEL_1;
		end else begin
			level = LEVEL_0;
		end
	end

	// Line boundary, feature tracking and table bookkeeping
	always_comb begin
		swap      = (si_q >= cfg.line_length);
		bank_n    = swap ? !bank_q : bank_q;
		cnt_cur   = swap ? '0 : cnt_q[bank_n];
		bc_eff    = swap ? '0 : bc_q;
		si_n      = (swap ? '0 : si_q) + 1'b1;
		sum_add   = {1'b0, rsum_q} + (SUM_W + 1)'(level);
		rsum_n    = rsum_q;
		bc_n      = bc_eff;
		gap_n     = gap_q;
		close     = 1'b0;

		if (level != LEVEL_0) begin
			if (rsum_q == '0) begin
				rsum_n = SUM_W'(level);
				bc_n   = BRIGHT_W'(1);
				gap_n  = cfg.gap_limit;
			end else if (bc_eff < cfg.feature_limit) begin
				rsum_n = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
				bc_n   = bc_eff + 1'b1;
				gap_n  = cfg.gap_limit;
			end else begin
				close = 1'b1;
			end
		end else if (rsum_q != '0) begin
			if (gap_q == '0) begin
				close = 1'b1;
			end else begin
				gap_n = gap_q - 1'b1;
			end
		end

		if (close) begin
			rsum_n = '0;
			bc_n   = '0;
		end

		store     = close && (cnt_cur < CNT_W'(TABLE_DEPTH));
		cnt_cur_n = store ? cnt_cur + 1'b1 : cnt_cur;

		q_job.bank     = bank_n;
		q_job.idx      = cnt_cur[IDX_W-1:0];
		q_job.prev_cnt = cnt_q[!bank_n];
		q_job.sum      = rsum_q;
		q_job.pos      = {1'b0, si_n} - POS_W'(bc_eff);
	end

	assign q_push = accept && store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsum_q   <= '0;
			bc_q     <= '0;
			gap_q    <= '0;
			si_q     <= '0;
			bank_q   <= 1'b0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (accept) begin
			rsum_q        <= rsum_n;
			bc_q          <= bc_n;
			gap_q         <= gap_n;
			si_q          <= si_n;
			bank_q        <= bank_n;
			cnt_q[bank_n] <= cnt_cur_n;
		end
	end

endmodule

### hw/rtl/lfdt_back.sv
// Back part: stores each ended feature in its bank and searches the other
// bank for the first unused match. Depends on lfdt_pkg, lfdt_ram, macros.
`timescale 1ns / 1ps
`include "line_feature_displacement_tracker_assert.svh"

module lfdt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     match_window,
	input  logic           q_vld,
	input  lfdt_pkg::job_t q_job,
	output logic           q_pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata   // [12:0] displacement, [15:13] zero
);
	import lfdt_pkg::*;

	localparam int ENT_W = SUM_W + POS_W;

	back_state_t       state_q;
	back_state_t       state_n;
	job_t              job_q;
	logic [CNT_W-1:0]  j_q;
	logic [IDX_W-1:0]  j_s1;
	logic              rd_vld_s1;
	logic [2*TABLE_DEPTH-1:0] used_q;
	logic              out_vld_q;
	logic [POS_W-1:0]  out_disp_q;

	logic              start;
	logic              ram_we;
	logic              issue;
	logic              done;
	logic              hit;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] chk_addr;
	logic [ENT_W-1:0]  rdata;
	logic [SUM_W-1:0]  ent_sum;
	logic [POS_W-1:0]  ent_pos;
	logic [SUM_W-1:0]  diff;

	assign start = q_vld && (!out_vld_q || m_tready);

	// Feature table, both banks
	lfdt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(2 * TABLE_DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata({job_q.sum, job_q.pos}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Compare stage on the registered table read
	assign ent_sum  = rdata[ENT_W-1:POS_W];
	assign ent_pos  = rdata[POS_W-1:0];
	assign diff     = (job_q.sum > ent_sum) ? job_q.sum - ent_sum : ent_sum - job_q.sum;
	assign chk_addr = tbl_addr(!job_q.bank, j_s1);
	assign hit      = rd_vld_s1 && !used_q[chk_addr]
	                  && (diff < SUM_W'(match_window)) && (job_q.pos > ent_pos);

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE:   if (start) state_n = BK_WRITE;
			BK_WRITE:  state_n = BK_SEARCH;
			BK_SEARCH: if (done) state_n = BK_IDLE;
			default:   state_n = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		q_pop  = 1'b0;
		ram_we = 1'b0;
		issue  = 1'b0;
		done   = 1'b0;
		waddr  = tbl_addr(job_q.bank, job_q.idx);
		raddr  = tbl_addr(!job_q.bank, j_q[IDX_W-1:0]);
		unique case (state_q)
			BK_IDLE: begin
				q_pop = start;
			end
			BK_WRITE: begin
				ram_we = 1'b1;
			end
			BK_SEARCH: begin
				issue = (j_q < job_q.prev_cnt) && !hit;
				done  = hit || ((j_q >= job_q.prev_cnt) && !rd_vld_s1);
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (issue) begin
			j_s1 <= j_q[IDX_W-1:0];
		end
		if (hit) begin
			out_disp_q <= job_q.pos - ent_pos;
		end
	end

	// Control: state, search index, used marks, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			j_q       <= '0;
			rd_vld_s1 <= 1'b0;
			used_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= issue;
			if (ram_we) begin
				j_q           <= '0;
				used_q[waddr] <= 1'b0;
			end else if (issue) begin
				j_q <= j_q + 1'b1;
			end
			if (hit) begin
				used_q[chk_addr] <= 1'b1;
				out_vld_q        <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_disp_q};

	`LFDT_ASSERT_SAME(a_hit_slot_free, hit, !out_vld_q, "match would overwrite pending result")
	`LFDT_ASSERT_SAME(a_read_in_search, rd_vld_s1, state_q == BK_SEARCH, "table read outside search")
	`LFDT_ASSERT_NEXT(a_hit_ends_job, hit, state_q == BK_IDLE, "search continued after a match")

endmodule
